// File: src/apf_pkg.sv
// apf_pkg: shared widths, ascii codes, job record and crc/hex helpers
// for the ascii packet framer; no dependencies
package apf_pkg;

    localparam int DATA_W  = 8;
    localparam int LEN_W   = 14;
    localparam int CRC_W   = 16;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
    localparam logic [LEN_W-1:0] LEN_DIGITS_MAX = 14'd9999;
    localparam logic [LEN_W-1:0] CNT_MAX = '1;

    localparam logic [DATA_W-1:0] ASCII_HASH = 8'h23;
    localparam logic [DATA_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [DATA_W-1:0] ASCII_A    = 8'h41;
    localparam logic [DATA_W-1:0] ASCII_CR   = 8'h0D;
    localparam logic [DATA_W-1:0] ASCII_LF   = 8'h0A;

    // reciprocal constants for decimal digit extraction
    localparam logic [27:0] RCP_1000 = 28'd8389;   // 2^-23 scale, v <= 9999
    localparam logic [15:0] RCP_100  = 16'd41;     // 2^-12 scale, r <= 999
    localparam logic [17:0] RCP_10   = 18'd205;    // 2^-11 scale, r <= 99

    // one classified payload beat as it waits for the back end
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              first;
        logic              last;
        logic [LEN_W-1:0]  len_sat;
        logic [CRC_W-1:0]  crc;
        logic              err;
    } t_job;

    // queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // fold one byte: shift right by 8, xor byte, eight reflected steps
    function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                  input logic [DATA_W-1:0] b);
        logic [CRC_W-1:0] r;
        r = (crc >> 8) ^ {8'd0, b};
        for (int i = 0; i < 8; i++) begin
            if (r[0]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // nibble to uppercase hex character
    function automatic logic [DATA_W-1:0] hex_char(input logic [3:0] n);
        logic [DATA_W-1:0] c;
        if (n < 4'd10) begin
            c = ASCII_ZERO + {4'd0, n};
        end else begin
            c = ASCII_A + {4'd0, n} - 8'd10;
        end
        return c;
    endfunction

endpackage

// File: src/apf_in_if.sv
// apf_in_if: payload input channel, valid/ready plus the payload fields
// depends on apf_pkg
interface apf_in_if import apf_pkg::*;;

    logic             valid;
    logic             ready;
    logic [DATA_W-1:0] data_byte;
    logic             first_byte;
    logic             last_byte;
    logic [LEN_W-1:0] frame_length;

    modport source (output valid, data_byte, first_byte, last_byte, frame_length,
                    input ready);
    modport sink   (input valid, data_byte, first_byte, last_byte, frame_length,
                    output ready);

endinterface

// File: src/apf_out_if.sv
// apf_out_if: framed output channel, valid/ready plus the result fields
// depends on apf_pkg
interface apf_out_if import apf_pkg::*;;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] out_byte;
    logic              run_end;
    logic              frame_done;
    logic              length_error;

    modport source (output valid, out_byte, run_end, frame_done, length_error,
                    input ready);
    modport sink   (input valid, out_byte, run_end, frame_done, length_error,
                    output ready);

endinterface

// File: src/apf_front.sv
// apf_front: accepts payload beats, runs crc, byte count and length check,
// pushes one job per beat; depends on apf_pkg and apf_in_if
module apf_front import apf_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    apf_in_if.sink        i_in,
    input  t_q_stat       i_q_stat,
    output logic          o_push,
    output t_job          o_job
);

    logic [CRC_W-1:0] r_crc, n_crc;
    logic [LEN_W-1:0] r_cnt, n_cnt;
    logic [LEN_W-1:0] r_decl, n_decl;
    logic [CRC_W-1:0] crc_base, crc_new;
    logic [LEN_W-1:0] cnt_base, cnt_new;
    logic             accept;

    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && !i_q_stat.full;

    // running state as seen by this beat
    always_comb begin
        crc_base = i_in.first_byte ? CRC_INIT : r_crc;
        cnt_base = i_in.first_byte ? '0 : r_cnt;
        n_decl   = i_in.first_byte ? i_in.frame_length : r_decl;
        crc_new  = crc_fold(crc_base, i_in.data_byte);
        cnt_new  = (cnt_base == CNT_MAX) ? cnt_base : cnt_base + 1'b1;
        n_crc    = i_in.last_byte ? CRC_INIT : crc_new;
        n_cnt    = i_in.last_byte ? '0 : cnt_new;
    end

    // job record for the back end
    always_comb begin
        o_push        = accept;
        o_job.data    = i_in.data_byte;
        o_job.first   = i_in.first_byte;
        o_job.last    = i_in.last_byte;
        o_job.len_sat = (i_in.frame_length > LEN_DIGITS_MAX) ? LEN_DIGITS_MAX
                                                             : i_in.frame_length;
        o_job.crc     = crc_new;
        o_job.err     = (cnt_new != n_decl);
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= CRC_INIT;
            r_cnt  <= '0;
            r_decl <= '0;
        end else if (accept) begin
            r_crc  <= n_crc;
            r_cnt  <= n_cnt;
            r_decl <= n_decl;
        end
    end

    a_crc_reset_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.last_byte |=> r_crc == CRC_INIT && r_cnt == '0)
        else $error("crc or count not restarted after frame end");

endmodule

// File: src/apf_queue.sv
// apf_queue: short fifo of jobs between front and back end
// depends on apf_pkg
module apf_queue import apf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_head,
    output t_q_stat o_stat
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("queue level beyond depth");

endmodule

// File: src/apf_back.sv
// apf_back: expands each job into header, payload and trailer beats,
// holds the output register; depends on apf_pkg and apf_out_if
module apf_back import apf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_head,
    input  t_q_stat   i_q_stat,
    output logic      o_pop,
    apf_out_if.source o_out
);

    localparam logic [3:0] P_H0   = 4'd0;
    localparam logic [3:0] P_H1   = 4'd1;
    localparam logic [3:0] P_D3   = 4'd2;
    localparam logic [3:0] P_D2   = 4'd3;
    localparam logic [3:0] P_D1   = 4'd4;
    localparam logic [3:0] P_D0   = 4'd5;
    localparam logic [3:0] P_BYTE = 4'd6;
    localparam logic [3:0] P_C3   = 4'd7;
    localparam logic [3:0] P_C2   = 4'd8;
    localparam logic [3:0] P_C1   = 4'd9;
    localparam logic [3:0] P_C0   = 4'd10;
    localparam logic [3:0] P_CR   = 4'd11;
    localparam logic [3:0] P_LF   = 4'd12;

    logic              r_started;
    logic [3:0]        r_pos, n_pos, pos;
    logic [3:0]        r_q;
    logic [9:0]        r_rem;
    logic              r_ovalid;
    logic [DATA_W-1:0] r_obyte, n_obyte;
    logic              r_orun, n_orun;
    logic              r_odone, n_odone;
    logic              r_oerr, n_oerr;
    logic              adv;
    logic [27:0]       prod_k;
    logic [LEN_W-1:0]  rem_k;
    logic [15:0]       prod_h;
    logic [9:0]        rem_h;
    logic [17:0]       prod_t;
    logic [9:0]        rem_u;

    assign adv   = !i_q_stat.empty && (!r_ovalid || o_out.ready);
    assign pos   = r_started ? r_pos : (i_head.first ? P_H0 : P_BYTE);
    assign o_pop = adv && n_orun;

    // decimal digits, one multiply per emitted header beat
    always_comb begin
        prod_k = {14'd0, i_head.len_sat} * RCP_1000;
        rem_k  = i_head.len_sat - LEN_W'(r_q) * 14'd1000;
        prod_h = {6'd0, r_rem} * RCP_100;
        rem_h  = r_rem - {6'd0, r_q} * 10'd100;
        prod_t = {8'd0, r_rem} * RCP_10;
        rem_u  = r_rem - {6'd0, r_q} * 10'd10;
    end

    // beat selection for the current position
    always_comb begin
        n_obyte = ASCII_HASH;
        n_orun  = 1'b0;
        n_odone = 1'b0;
        n_oerr  = 1'b0;
        n_pos   = pos + 1'b1;
        case (pos)
            P_H0:   n_obyte = ASCII_HASH;
            P_H1:   n_obyte = ASCII_HASH;
            P_D3:   n_obyte = ASCII_ZERO + {4'd0, r_q};
            P_D2:   n_obyte = ASCII_ZERO + {4'd0, r_q};
            P_D1:   n_obyte = ASCII_ZERO + {4'd0, prod_t[14:11]};
            P_D0:   n_obyte = ASCII_ZERO + {4'd0, rem_u[3:0]};
            P_BYTE: begin
                n_obyte = i_head.data;
                n_orun  = !i_head.last;
            end
            P_C3:   n_obyte = hex_char(i_head.crc[15:12]);
            P_C2:   n_obyte = hex_char(i_head.crc[11:8]);
            P_C1:   n_obyte = hex_char(i_head.crc[7:4]);
            P_C0:   n_obyte = hex_char(i_head.crc[3:0]);
            P_CR:   n_obyte = ASCII_CR;
            P_LF: begin
                n_obyte = ASCII_LF;
                n_orun  = 1'b1;
                n_odone = 1'b1;
                n_oerr  = i_head.err;
            end
            default: begin
                n_obyte = ASCII_HASH;
                n_orun  = 1'b1;
            end
        endcase
    end

    // position sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_pos     <= P_H0;
        end else if (adv) begin
            r_started <= !n_orun;
            r_pos     <= n_pos;
        end
    end

    // digit working registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            case (pos)
                P_H0: r_q   <= prod_k[26:23];
                P_H1: r_rem <= rem_k[9:0];
                P_D3: r_q   <= prod_h[15:12];
                P_D2: r_rem <= rem_h;
                P_D1: r_q   <= prod_t[14:11];
                default: begin
                    r_q   <= r_q;
                    r_rem <= r_rem;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (adv) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_obyte <= n_obyte;
            r_orun  <= n_orun;
            r_odone <= n_odone;
            r_oerr  <= n_oerr;
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.out_byte     = r_obyte;
    assign o_out.run_end      = r_orun;
    assign o_out.frame_done   = r_odone;
    assign o_out.length_error = r_oerr;

    a_started_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |-> !i_q_stat.empty)
        else $error("sequencer mid-job with empty queue");

    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && n_odone |-> n_orun && o_pop)
        else $error("frame end beat does not close its job");

    a_pop_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> !r_started)
        else $error("sequencer not restarted after job end");

endmodule

// File: src/ascii_packet_framer_crc16_top.sv
// ascii_packet_framer_crc16_top: top level of the packet framer
// depends on apf_pkg, apf_in_if, apf_out_if, apf_front, apf_queue, apf_back
//
// usage
//   i_in carries payload beats (data_byte, first_byte, last_byte,
//   frame_length) on valid/ready. o_out carries the framed stream, one
//   byte per beat, with run_end on the last beat caused by an input beat,
//   frame_done and length_error on the closing LF.
//   a first beat produces "##", four length digits and the byte; a last
//   beat produces the byte, four hex crc digits, CR and LF.
//   throughput: the front end takes one beat per cycle while its four-entry
//   queue has room; the back end emits one output beat per cycle while
//   o_out is not stalled, so a middle byte yields one output beat, a first
//   or last byte seven, both thirteen. with an empty queue, an accepted
//   beat reaches o_out through the queue write, then the output register.
//   reset clears crc to 0xFFFF, byte count and declared length to zero,
//   the queue and the output valid.
//   a stall on o_out holds the output register; the queue fills and then
//   i_in.ready drops until the back end moves again.
module ascii_packet_framer_crc16_top import apf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    apf_in_if.sink    i_in,
    apf_out_if.source o_out
);

    t_q_stat q_stat;
    t_job    push_job;
    t_job    head_job;
    logic    push;
    logic    pop;

    // classify and fold
    apf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_job    (push_job)
    );

    // decoupling queue
    apf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_stat  (q_stat)
    );

    // expand into framed beats
    apf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_job),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule
